// ----- hw/rtl/g4r_pkg.sv -----
// Shared types, register codes, reset values and the tint lookup for the rotator.
package g4r_pkg;

  localparam int PIXEL_W      = 8;
  localparam int NIBBLE_W     = 4;
  localparam int DEST_W       = 20;
  localparam int COLOR_W      = 16;
  localparam int OUT_TDATA_W  = 40;
  localparam int OUT_PAD_W    = OUT_TDATA_W - DEST_W - COLOR_W;
  localparam int CFG_INDEX_W  = 3;
  localparam int CFG_DATA_W   = 11;
  localparam int ORIENT_W     = 2;
  localparam int QUEUE_DEPTH  = 4;
  localparam int SETTLE_W     = 2;

  // Cycles the derived geometry needs after a register write.
  localparam logic [SETTLE_W-1:0] SETTLE_CYCLES = 2'd2;

  // Register indexes on the configuration channel.
  localparam logic [CFG_INDEX_W-1:0] REG_SCREEN_WIDTH  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SCREEN_HEIGHT = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_ORIENTATION   = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_BACKLIGHT_ON  = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_CLIP_TOP      = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_CLIP_BOTTOM   = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_CLIP_LEFT     = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_CLIP_RIGHT    = 3'd7;

  // Orientation codes.
  localparam logic [ORIENT_W-1:0] ORIENT_NONE   = 2'd0;
  localparam logic [ORIENT_W-1:0] ORIENT_RIGHT  = 2'd1;
  localparam logic [ORIENT_W-1:0] ORIENT_LEFT   = 2'd2;
  localparam logic [ORIENT_W-1:0] ORIENT_ROT180 = 2'd3;

  // Register reset values.
  localparam logic [CFG_DATA_W-1:0] RST_SCREEN_WIDTH  = 11'd320;
  localparam logic [CFG_DATA_W-1:0] RST_SCREEN_HEIGHT = 11'd480;
  localparam logic [CFG_DATA_W-1:0] RST_CLIP_TOP      = 11'd0;
  localparam logic [CFG_DATA_W-1:0] RST_CLIP_BOTTOM   = 11'd480;
  localparam logic [CFG_DATA_W-1:0] RST_CLIP_LEFT     = 11'd0;
  localparam logic [CFG_DATA_W-1:0] RST_CLIP_RIGHT    = 11'd320;

  // Replicate a gray nibble into RGB565: green tint with backlight, white tint without.
  function automatic logic [COLOR_W-1:0] tint(input logic [NIBBLE_W-1:0] a,
                                               input logic backlight);
    if (backlight) begin
      return {1'b0, a, a, 3'b000, a};
    end
    return {a, 1'b0, a, 2'b00, a, 1'b0};
  endfunction

endpackage

// ----- hw/rtl/g4r_cfg.sv -----
// Configuration registers and the registered region geometry derived from them.
module g4r_cfg #(
  parameter int MAX_DIM = 1024,
  parameter int DW      = 11
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [g4r_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [g4r_pkg::CFG_DATA_W-1:0]    cfg_data,
  output logic [DW-1:0]                     wdt,
  output logic [DW-1:0]                     hgt,
  output logic [DW-1:0]                     top,
  output logic [DW-1:0]                     left,
  output logic [DW-1:0]                     nrows,
  output logic [DW-1:0]                     span,
  output logic [g4r_pkg::DEST_W-1:0]        wh,
  output logic [g4r_pkg::ORIENT_W-1:0]      orient,
  output logic                              backlight,
  output logic                              region_empty,
  output logic                              busy
);
  import g4r_pkg::*;

  localparam int WW = (DW > CFG_DATA_W) ? DW : CFG_DATA_W;

  logic [CFG_DATA_W-1:0] screen_width, screen_height;
  logic [CFG_DATA_W-1:0] clip_top, clip_bottom, clip_left, clip_right;
  logic [ORIENT_W-1:0]   orientation;
  logic                  backlight_on;
  logic [SETTLE_W-1:0]   settle;

  logic [WW-1:0] w_sat, h_sat, bot, rgt, lft, tp, nr, sp;
  logic [WW-1:0] sw_x, sh_x, cb_x, cr_x;
  logic [2*DW-1:0] area;

  assign cfg_ready = 1'b1;
  assign busy      = (settle != '0);
  assign orient    = orientation;
  assign backlight = backlight_on;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= RST_SCREEN_WIDTH;
      screen_height <= RST_SCREEN_HEIGHT;
      orientation   <= ORIENT_NONE;
      backlight_on  <= 1'b0;
      clip_top      <= RST_CLIP_TOP;
      clip_bottom   <= RST_CLIP_BOTTOM;
      clip_left     <= RST_CLIP_LEFT;
      clip_right    <= RST_CLIP_RIGHT;
      settle        <= SETTLE_CYCLES;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_SCREEN_WIDTH:  screen_width  <= cfg_data;
          REG_SCREEN_HEIGHT: screen_height <= cfg_data;
          REG_ORIENTATION:   orientation   <= cfg_data[ORIENT_W-1:0];
          REG_BACKLIGHT_ON:  backlight_on  <= cfg_data[0];
          REG_CLIP_TOP:      clip_top      <= cfg_data;
          REG_CLIP_BOTTOM:   clip_bottom   <= cfg_data;
          REG_CLIP_LEFT:     clip_left     <= cfg_data;
          REG_CLIP_RIGHT:    clip_right    <= cfg_data;
          default: ;
        endcase
        settle <= SETTLE_CYCLES;
      end else if (settle != '0) begin
        settle <= settle - SETTLE_W'(1);
      end
    end
  end

  always_comb begin
    sw_x  = WW'(screen_width);
    sh_x  = WW'(screen_height);
    cb_x  = WW'(clip_bottom);
    cr_x  = WW'(clip_right);
    w_sat = (sw_x > WW'(MAX_DIM)) ? WW'(MAX_DIM) : sw_x;
    h_sat = (sh_x > WW'(MAX_DIM)) ? WW'(MAX_DIM) : sh_x;
    bot   = (cb_x > h_sat) ? h_sat : cb_x;
    rgt   = (cr_x > w_sat) ? w_sat : cr_x;
    lft   = WW'({clip_left[CFG_DATA_W-1:1], 1'b0});
    tp    = WW'(clip_top);
    if (orientation == ORIENT_NONE) begin
      nr = (bot > tp) ? bot - tp : '0;
      sp = (rgt > lft) ? rgt - lft : '0;
    end else begin
      nr = h_sat;
      sp = w_sat;
    end
  end

  // Top and left fit DW whenever an unrotated region is not empty.
  always_ff @(posedge clk) begin
    wdt          <= DW'(w_sat);
    hgt          <= DW'(h_sat);
    top          <= DW'(tp);
    left         <= DW'(lft);
    nrows        <= DW'(nr);
    span         <= DW'(sp);
    region_empty <= (nr == '0) || (sp == '0);
    wh           <= DEST_W'(area);
  end

  assign area = wdt * hgt;

endmodule

// ----- hw/rtl/g4r_front.sv -----
// Front end: accepts source bytes, steps the row and column counters, queues work.
module g4r_front #(
  parameter int DW = 11,
  parameter int EW = 31
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [g4r_pkg::PIXEL_W-1:0]    s_tdata,
  input  logic                           s_tuser,
  input  logic [DW-1:0]                  nrows,
  input  logic [DW-1:0]                  span,
  input  logic                           region_empty,
  input  logic                           busy,
  input  logic                           queue_full,
  output logic                           push,
  output logic [EW-1:0]                  push_data
);
  import g4r_pkg::*;

  localparam int CW = DW + 1;

  logic [DW-1:0] row_count, column_count;
  logic [DW-1:0] row_count_next, column_count_next;
  logic [CW-1:0] nr_x, sp_x, r0, c0, ra, r1, c1, cn, rb;
  logic          wrap_a, wrap_b, last;

  assign s_tready = !busy && !queue_full;
  assign push     = s_tvalid && s_tready && !region_empty;

  always_comb begin
    nr_x = CW'(nrows);
    sp_x = CW'(span);
    r0   = s_tuser ? '0 : CW'(row_count);
    c0   = s_tuser ? '0 : CW'(column_count);
    // Wrap counters left out of range by a geometry change.
    wrap_a = (c0 >= sp_x);
    c1     = wrap_a ? '0 : c0;
    ra     = wrap_a ? r0 + CW'(1) : r0;
    r1     = (ra >= nr_x) ? '0 : ra;
    last   = (r1 + CW'(1) >= nr_x) && (c1 + CW'(2) >= sp_x);
    // Advance by one pixel pair.
    cn     = c1 + CW'(2);
    wrap_b = (cn >= sp_x);
    rb     = wrap_b ? r1 + CW'(1) : r1;
    column_count_next = wrap_b ? '0 : DW'(cn);
    row_count_next    = (rb >= nr_x) ? '0 : DW'(rb);
  end

  assign push_data = {s_tdata, DW'(r1), DW'(c1), last};

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count    <= '0;
      column_count <= '0;
    end else if (push) begin
      row_count    <= row_count_next;
      column_count <= column_count_next;
    end
  end

endmodule

// ----- hw/rtl/g4r_fifo.sv -----
// Short work queue between the front end and the address back end.
module g4r_fifo #(
  parameter int WIDTH = 31,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             valid,
  output logic [WIDTH-1:0] pop_data
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] slots [DEPTH];
  logic [AW:0]      wr_ptr, rd_ptr;
  logic [AW:0]      fill;

  assign fill     = wr_ptr - rd_ptr;
  assign full     = (fill == (AW+1)'(DEPTH));
  assign valid    = (fill != '0);
  assign pop_data = slots[rd_ptr[AW-1:0]];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr[AW-1:0] == AW'(DEPTH - 1))
                  ? {~wr_ptr[AW], {AW{1'b0}}} : wr_ptr + (AW+1)'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr[AW-1:0] == AW'(DEPTH - 1))
                  ? {~rd_ptr[AW], {AW{1'b0}}} : rd_ptr + (AW+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr[AW-1:0]] <= push_data;
    end
  end

endmodule

// ----- hw/rtl/g4r_back.sv -----
// Back end: destination index arithmetic, tint lookup and the two-word output register.
module g4r_back #(
  parameter int DW = 11,
  parameter int EW = 31
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              queue_valid,
  input  logic [EW-1:0]                     queue_data,
  output logic                              pop,
  input  logic [DW-1:0]                     wdt,
  input  logic [DW-1:0]                     hgt,
  input  logic [DW-1:0]                     top,
  input  logic [DW-1:0]                     left,
  input  logic [g4r_pkg::DEST_W-1:0]        wh,
  input  logic [g4r_pkg::ORIENT_W-1:0]      orient,
  input  logic                              backlight,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [g4r_pkg::OUT_TDATA_W-1:0]   m_tdata,
  output logic                              m_tlast,
  output logic                              m_tuser
);
  import g4r_pkg::*;

  localparam int CW = DW + 1;

  logic [PIXEL_W-1:0] q_byte;
  logic [DW-1:0]      q_row, q_col;
  logic               q_last;

  logic [CW-1:0]      mul_a;
  logic [DW-1:0]      mul_b;
  logic [CW+DW-1:0]   mul_p;
  logic [DEST_W-1:0]  k0, k1, r20, c20, h20, l20;
  logic               neg;

  // Stage one: product and offsets.
  logic               s1_valid;
  logic [DEST_W-1:0]  s1_prod, s1_k0, s1_k1;
  logic               s1_neg, s1_last;
  logic [COLOR_W-1:0] s1_color_hi, s1_color_lo;

  // Output register: one pixel pair, shown as two words.
  logic               s2_valid, s2_half, s2_last;
  logic [DEST_W-1:0]  s2_dest0, s2_dest1;
  logic [COLOR_W-1:0] s2_color_hi, s2_color_lo;

  logic               s2_take, s1_move;

  assign {q_byte, q_row, q_col, q_last} = queue_data;

  assign s2_take = s2_valid && s2_half && m_tready;
  assign s1_move = s1_valid && (!s2_valid || s2_take);
  assign pop     = queue_valid && (!s1_valid || s1_move);

  always_comb begin
    r20 = DEST_W'(q_row);
    c20 = DEST_W'(q_col);
    h20 = DEST_W'(hgt);
    l20 = DEST_W'(left);
    unique case (orient)
      ORIENT_NONE: begin
        mul_a = CW'(top) + CW'(q_row);
        mul_b = wdt;
        k0    = l20 + c20;
        k1    = l20 + c20 + DEST_W'(1);
        neg   = 1'b0;
      end
      ORIENT_RIGHT: begin
        mul_a = CW'(q_col);
        mul_b = hgt;
        k0    = wh - h20 + r20;
        k1    = wh - {h20[DEST_W-2:0], 1'b0} + r20;
        neg   = 1'b1;
      end
      ORIENT_LEFT: begin
        mul_a = CW'(q_col);
        mul_b = hgt;
        k0    = h20 - DEST_W'(1) - r20;
        k1    = {h20[DEST_W-2:0], 1'b0} - DEST_W'(1) - r20;
        neg   = 1'b0;
      end
      default: begin
        mul_a = CW'(q_row);
        mul_b = wdt;
        k0    = wh - DEST_W'(1) - c20;
        k1    = wh - DEST_W'(2) - c20;
        neg   = 1'b1;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  always_ff @(posedge clk) begin
    if (pop) begin
      s1_prod     <= DEST_W'(mul_p);
      s1_k0       <= k0;
      s1_k1       <= k1;
      s1_neg      <= neg;
      s1_last     <= q_last;
      s1_color_hi <= tint(q_byte[PIXEL_W-1:NIBBLE_W], backlight);
      s1_color_lo <= tint(q_byte[NIBBLE_W-1:0], backlight);
    end
    if (s1_move) begin
      s2_dest0    <= s1_neg ? s1_k0 - s1_prod : s1_k0 + s1_prod;
      s2_dest1    <= s1_neg ? s1_k1 - s1_prod : s1_k1 + s1_prod;
      s2_color_hi <= s1_color_hi;
      s2_color_lo <= s1_color_lo;
      s2_last     <= s1_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s2_half  <= 1'b0;
    end else begin
      if (pop) begin
        s1_valid <= 1'b1;
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end
      if (s1_move) begin
        s2_valid <= 1'b1;
        s2_half  <= 1'b0;
      end else if (s2_valid && m_tready) begin
        // Advance to the low nibble, then drop the pair.
        if (!s2_half) begin
          s2_half <= 1'b1;
        end else begin
          s2_valid <= 1'b0;
        end
      end
    end
  end

  assign m_tvalid = s2_valid;
  assign m_tuser  = s2_half;
  assign m_tlast  = s2_half && s2_last;
  assign m_tdata  = s2_half ? {{OUT_PAD_W{1'b0}}, s2_color_lo, s2_dest1}
                            : {{OUT_PAD_W{1'b0}}, s2_color_hi, s2_dest0};

endmodule

// ----- hw/rtl/gray4_to_rgb565_rotator.sv -----
// Top level: packed 4-bit gray framebuffer bytes to rotated RGB565 pixel words.
// Usage:
//   s_* channel takes one word per source byte, two gray pixels, high nibble
//   first; s_tuser restarts the position counters at that byte.
//   m_* channel gives two words per byte: destination index and RGB565 color,
//   m_tuser set on the low-nibble word, m_tlast on the low-nibble word of the
//   last byte of the frame or of the clipped region.
//   cfg_* channel writes one register per word and is always ready.
// Timing:
//   A taken byte goes through the queue and stage one to the output register;
//   later bytes are taken meanwhile. Output is one word per cycle while m_tready
//   is high. Index math is one multiplier stage and one add stage.
//   Bytes that fall in an empty region are taken and give no words.
// Reset and configuration:
//   Reset loads the register defaults and clears the counters and queue.
//   s_tready stays low after reset and after each register write
//   while the region geometry settles.
// Stalls:
//   When m_tready is low the output word holds; a 4-entry byte queue keeps the
//   input side taking bytes until it fills.
module gray4_to_rgb565_rotator #(
  parameter int MAX_DIM = 1024
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [g4r_pkg::PIXEL_W-1:0]       s_tdata,   // [7:0] pixel_pair
  input  logic                              s_tuser,   // [0] frame_start
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [g4r_pkg::OUT_TDATA_W-1:0]   m_tdata,   // [19:0] dest_index, [35:20] color
  output logic                              m_tlast,   // frame_end
  output logic                              m_tuser,   // [0] second_of_pair
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [g4r_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [g4r_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import g4r_pkg::*;

  localparam int DW = $clog2(MAX_DIM) + 1;
  localparam int EW = PIXEL_W + 2 * DW + 1;

  logic [DW-1:0]     wdt, hgt, top, left, nrows, span;
  logic [DEST_W-1:0] wh;
  logic [ORIENT_W-1:0] orient;
  logic              backlight, region_empty, busy;
  logic              push, queue_full, queue_valid, pop;
  logic [EW-1:0]     push_data, queue_data;

  g4r_cfg #(.MAX_DIM(MAX_DIM), .DW(DW)) u_cfg (
    .clk, .rst,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .wdt, .hgt, .top, .left, .nrows, .span, .wh,
    .orient, .backlight, .region_empty, .busy
  );

  g4r_front #(.DW(DW), .EW(EW)) u_front (
    .clk, .rst,
    .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .nrows, .span, .region_empty, .busy,
    .queue_full, .push, .push_data
  );

  g4r_fifo #(.WIDTH(EW), .DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk, .rst,
    .push, .push_data, .full(queue_full),
    .pop, .valid(queue_valid), .pop_data(queue_data)
  );

  g4r_back #(.DW(DW), .EW(EW)) u_back (
    .clk, .rst,
    .queue_valid, .queue_data, .pop,
    .wdt, .hgt, .top, .left, .wh, .orient, .backlight,
    .m_tvalid, .m_tready, .m_tdata, .m_tlast, .m_tuser
  );

endmodule

// ----- hw/rtl/g4r_checker.sv -----
// Port-level checks for the rotator and the bind that attaches them.
module g4r_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              s_tready,
  input logic                              m_tvalid,
  input logic                              m_tready,
  input logic [g4r_pkg::OUT_TDATA_W-1:0]   m_tdata,
  input logic                              m_tlast,
  input logic                              m_tuser,
  input logic                              cfg_valid,
  input logic                              cfg_ready
);

  // Frame end only rides on the low-nibble word.
  a_last_on_second: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tlast) |-> m_tuser)
    else $error("frame end on a high-nibble word");

  // The low-nibble word follows its high-nibble word at once.
  a_pair_follows: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && !m_tuser) |=> (m_tvalid && m_tuser))
    else $error("second word of a pair missing");

  // Input holds off while geometry settles after a write.
  a_cfg_settle: assert property (@(posedge clk) disable iff (rst)
    (cfg_valid && cfg_ready) |=> !s_tready)
    else $error("byte taken during geometry settle");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> (!m_tvalid && !s_tready))
    else $error("channels active right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                 && $stable(m_tlast)))
    else $error("stalled output word changed");

endmodule

bind gray4_to_rgb565_rotator g4r_checker u_g4r_checker (
  .clk(clk),
  .rst(rst),
  .s_tready(s_tready),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata(m_tdata),
  .m_tlast(m_tlast),
  .m_tuser(m_tuser),
  .cfg_valid(cfg_valid),
  .cfg_ready(cfg_ready)
);

// ----- bench/tb.sv -----
// Testbench for gray4_to_rgb565_rotator: random framebuffer bytes checked against a predictor.
`timescale 1ns / 1ps

module tb;
  import g4r_pkg::*;

  localparam int MAX_DIM     = 1024;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    logic [PIXEL_W-1:0] pair;
    logic               start;
  } src_byte_t;

  typedef struct packed {
    logic [DEST_W-1:0]  dest;
    logic [COLOR_W-1:0] color;
    logic               second;
    logic               frame_end;
  } pixel_word_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [PIXEL_W-1:0]     s_tdata = '0;
  logic                   s_tuser = 1'b0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   m_tlast;
  logic                   m_tuser;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  gray4_to_rgb565_rotator #(.MAX_DIM(MAX_DIM)) dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // Register shadow, as the block holds it after reset.
  logic [CFG_DATA_W-1:0] sh_width     = RST_SCREEN_WIDTH;
  logic [CFG_DATA_W-1:0] sh_height    = RST_SCREEN_HEIGHT;
  logic [ORIENT_W-1:0]   sh_orient    = ORIENT_NONE;
  logic                  sh_backlight = 1'b0;
  logic [CFG_DATA_W-1:0] sh_clip_top    = RST_CLIP_TOP;
  logic [CFG_DATA_W-1:0] sh_clip_bottom = RST_CLIP_BOTTOM;
  logic [CFG_DATA_W-1:0] sh_clip_left   = RST_CLIP_LEFT;
  logic [CFG_DATA_W-1:0] sh_clip_right  = RST_CLIP_RIGHT;

  // Position within the region.
  int unsigned grid_row = 0;
  int unsigned grid_col = 0;

  src_byte_t   bytes_to_send[$];
  pixel_word_t pixels_due[$];

  int src_idle_pct   = 0;
  int sink_stall_pct = 0;
  bit hold_req       = 1'b0;
  int hold_left      = 0;
  int cycles         = 0;
  int errors         = 0;
  int bytes_taken    = 0;
  int words_checked  = 0;
  int frame_ends     = 0;
  int reg_writes     = 0;

  function automatic logic [COLOR_W-1:0] gray_to_565(input logic [NIBBLE_W-1:0] g);
    logic [COLOR_W-1:0] v;
    v = {{(COLOR_W-NIBBLE_W){1'b0}}, g};
    if (sh_backlight)
      return (v << 11) | (v << 7) | v;
    return (v << 12) | (v << 7) | (v << 1);
  endfunction

  function automatic void region_of(output int unsigned wdt, output int unsigned hgt,
                                    output int unsigned top, output int unsigned left,
                                    output int unsigned nrows, output int unsigned span);
    int unsigned bot, rgt;
    wdt = (sh_width > MAX_DIM) ? MAX_DIM : 32'(sh_width);
    hgt = (sh_height > MAX_DIM) ? MAX_DIM : 32'(sh_height);
    top = 0;
    left = 0;
    if (sh_orient == ORIENT_NONE) begin
      bot = (sh_clip_bottom > hgt) ? hgt : 32'(sh_clip_bottom);
      rgt = (sh_clip_right > wdt) ? wdt : 32'(sh_clip_right);
      top = 32'(sh_clip_top);
      left = 32'({sh_clip_left[CFG_DATA_W-1:1], 1'b0});
      nrows = (bot > top) ? bot - top : 0;
      span = (rgt > left) ? rgt - left : 0;
    end else begin
      nrows = hgt;
      span = wdt;
    end
  endfunction

  // Work out the two pixel words one source byte gives, and advance the position.
  function automatic void predict_pixels(input logic [PIXEL_W-1:0] pair, input logic start);
    int unsigned wdt, hgt, top, left, nrows, span, d0, d1;
    logic        is_end;
    pixel_word_t w;
    region_of(wdt, hgt, top, left, nrows, span);
    if (nrows == 0 || span == 0)
      return;
    if (start) begin
      grid_row = 0;
      grid_col = 0;
    end
    // Wrap counters left out of range by a register change.
    if (grid_col >= span) begin
      grid_col = 0;
      grid_row++;
    end
    if (grid_row >= nrows)
      grid_row = 0;
    case (sh_orient)
      ORIENT_NONE: begin
        d0 = (top + grid_row) * wdt + left + grid_col;
        d1 = d0 + 1;
      end
      ORIENT_RIGHT: begin
        d0 = hgt * (wdt - 1) + grid_row - grid_col * hgt;
        d1 = d0 - hgt;
      end
      ORIENT_LEFT: begin
        d0 = (hgt - 1 - grid_row) + grid_col * hgt;
        d1 = d0 + hgt;
      end
      default: begin
        d0 = wdt * hgt - 1 - (grid_row * wdt + grid_col);
        d1 = d0 - 1;
      end
    endcase
    is_end = (grid_row + 1 >= nrows) && (grid_col + 2 >= span);
    grid_col += 2;
    if (grid_col >= span) begin
      grid_col = 0;
      grid_row++;
      if (grid_row >= nrows)
        grid_row = 0;
    end
    w = '{d0[DEST_W-1:0], gray_to_565(pair[7:4]), 1'b0, 1'b0};
    pixels_due.push_back(w);
    w = '{d1[DEST_W-1:0], gray_to_565(pair[3:0]), 1'b1, is_end};
    pixels_due.push_back(w);
  endfunction

  function automatic void push_byte(input logic [PIXEL_W-1:0] p, input logic s);
    bytes_to_send.push_back('{p, s});
  endfunction

  // Source side: offer the next byte, or idle.
  always @(posedge clk) begin : byte_driver
    src_byte_t nxt;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (bytes_to_send.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
        nxt = bytes_to_send.pop_front();
        s_tvalid <= 1'b1;
        s_tdata <= nxt.pair;
        s_tuser <= nxt.start;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) begin
      predict_pixels(s_tdata, s_tuser);
      bytes_taken++;
    end
  end

  // Long output hold-off, counted here.
  always @(posedge clk) begin
    if (hold_req)
      hold_left <= HOLD_CYCLES;
    else if (hold_left != 0)
      hold_left <= hold_left - 1;
  end

  always @(posedge clk) begin
    if (rst)
      m_tready <= 1'b0;
    else
      m_tready <= (hold_left == 0) && !hold_req && ($urandom_range(99) >= sink_stall_pct);
  end

  always @(posedge clk) begin : word_monitor
    pixel_word_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = '{m_tdata[DEST_W-1:0], m_tdata[DEST_W +: COLOR_W], m_tuser, m_tlast};
      if (got.frame_end)
        frame_ends++;
      if (pixels_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected word: got dest %h color %h second %b end %b",
                 $realtime, got.dest, got.color, got.second, got.frame_end);
      end else begin
        want = pixels_due.pop_front();
        words_checked++;
        if (got !== want) begin
          errors++;
          $display("%0t: mismatch (dest color second end): expected %h %h %b %b, got %h %h %b %b",
                   $realtime, want.dest, want.color, want.second, want.frame_end,
                   got.dest, got.color, got.second, got.frame_end);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words still due", cycles, pixels_due.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_SCREEN_WIDTH:  sh_width = val;
      REG_SCREEN_HEIGHT: sh_height = val;
      REG_ORIENTATION:   sh_orient = val[ORIENT_W-1:0];
      REG_BACKLIGHT_ON:  sh_backlight = val[0];
      REG_CLIP_TOP:      sh_clip_top = val;
      REG_CLIP_BOTTOM:   sh_clip_bottom = val;
      REG_CLIP_LEFT:     sh_clip_left = val;
      default:           sh_clip_right = val;
    endcase
    reg_writes++;
    @(negedge clk);
  endtask

  // Wait until every byte is taken and every word is out, then let the pipe empty.
  task automatic wait_idle();
    do @(negedge clk);
    while (bytes_to_send.size() != 0 || s_tvalid || pixels_due.size() != 0);
    repeat (8) @(negedge clk);
  endtask

  task automatic setup(input int unsigned w, input int unsigned h, input logic [1:0] orient,
                       input logic bl, input int unsigned t, input int unsigned b,
                       input int unsigned l, input int unsigned r);
    write_reg(REG_SCREEN_WIDTH, w[CFG_DATA_W-1:0]);
    write_reg(REG_SCREEN_HEIGHT, h[CFG_DATA_W-1:0]);
    // Upper data bits are don't-care for the narrow registers; toggle them.
    write_reg(REG_ORIENTATION, {9'($urandom), orient});
    write_reg(REG_BACKLIGHT_ON, {10'($urandom), bl});
    write_reg(REG_CLIP_TOP, t[CFG_DATA_W-1:0]);
    write_reg(REG_CLIP_BOTTOM, b[CFG_DATA_W-1:0]);
    write_reg(REG_CLIP_LEFT, l[CFG_DATA_W-1:0]);
    write_reg(REG_CLIP_RIGHT, r[CFG_DATA_W-1:0]);
  endtask

  task automatic random_setup();
    int unsigned w, h, t, b, l, r;
    w = ($urandom_range(99) < 85) ? $urandom_range(2, 12) : $urandom_range(13, 2047);
    h = ($urandom_range(99) < 85) ? $urandom_range(1, 6) : $urandom_range(7, 2047);
    t = $urandom_range(0, h - 1);
    b = $urandom_range(t + 1, h + 3);
    l = $urandom_range(0, w - 1);
    r = $urandom_range(l + 1, w + 3);
    if ($urandom_range(9) == 0) begin
      t = $urandom_range(2047);
      b = $urandom_range(2047);
      l = $urandom_range(2047);
      r = $urandom_range(2047);
    end
    setup(w, h, 2'($urandom_range(3)), 1'($urandom_range(1)), t, b, l, r);
  endtask

  // Queue mostly whole frames with random pixels, plus follow-on, cut-short and stray bytes.
  task automatic queue_frames(input int target);
    int unsigned wdt, hgt, top, left, nrows, span;
    int          sent, n, kind;
    logic        s;
    sent = 0;
    while (sent < target) begin
      region_of(wdt, hgt, top, left, nrows, span);
      if (nrows == 0 || span == 0) begin
        // Empty region: the byte is dropped; then open the clip up.
        push_byte(8'($urandom), 1'($urandom_range(1)));
        wait_idle();
        write_reg(REG_CLIP_TOP, '0);
        write_reg(REG_CLIP_BOTTOM, '1);
        write_reg(REG_CLIP_LEFT, '0);
        write_reg(REG_CLIP_RIGHT, '1);
      end else begin
        n = nrows * ((span + 1) / 2);
        kind = $urandom_range(99);
        if (kind >= 90)
          n = $urandom_range(1, 6);
        else if (kind >= 80)
          n = $urandom_range(1, n);
        if (n > target - sent)
          n = target - sent;
        for (int i = 0; i < n; i++) begin
          if (kind >= 90)
            s = ($urandom_range(3) == 0);
          else
            s = (i == 0) && (kind < 70 || kind >= 80);
          push_byte(8'($urandom), s);
        end
        sent += n;
      end
    end
  endtask

  task automatic set_idle(input int mode);
    case (mode)
      0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
      1: begin src_idle_pct = 76; sink_stall_pct = 0;  end
      2: begin src_idle_pct = 0;  sink_stall_pct = 76; end
      default: begin src_idle_pct = 29; sink_stall_pct = 29; end
    endcase
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset geometry, white tint, nibble extremes.
    push_byte(8'h00, 1'b1);
    push_byte(8'hFF, 1'b0);
    push_byte(8'hF0, 1'b0);
    push_byte(8'h0F, 1'b0);
    wait_idle();

    // Rotate right on an odd-width screen, green tint; fifth byte wraps to a new frame.
    write_reg(REG_BACKLIGHT_ON, '1);
    write_reg(REG_ORIENTATION, CFG_DATA_W'(ORIENT_RIGHT));
    write_reg(REG_SCREEN_WIDTH, 11'd3);
    write_reg(REG_SCREEN_HEIGHT, 11'd2);
    push_byte(8'hA5, 1'b1);
    push_byte(8'h5A, 1'b0);
    push_byte(8'h3C, 1'b0);
    push_byte(8'hC3, 1'b0);
    push_byte(8'h96, 1'b0);
    wait_idle();

    // Rotate 180 on the odd width: the last index wraps below zero.
    write_reg(REG_ORIENTATION, CFG_DATA_W'(ORIENT_ROT180));
    push_byte(8'h12, 1'b1);
    push_byte(8'h34, 1'b0);
    push_byte(8'h56, 1'b0);
    push_byte(8'h78, 1'b0);
    wait_idle();

    // Rotate left with an oversized width that saturates.
    write_reg(REG_ORIENTATION, CFG_DATA_W'(ORIENT_LEFT));
    write_reg(REG_SCREEN_WIDTH, '1);
    write_reg(REG_SCREEN_HEIGHT, 11'd1);
    push_byte(8'h9A, 1'b1);
    push_byte(8'hBC, 1'b0);
    wait_idle();

    // Empty clip region: the byte gives nothing.
    write_reg(REG_ORIENTATION, CFG_DATA_W'(ORIENT_NONE));
    write_reg(REG_CLIP_TOP, 11'd5);
    write_reg(REG_CLIP_BOTTOM, 11'd5);
    push_byte(8'hDE, 1'b1);
    wait_idle();

    // Odd clip_left, limited bottom and right; then shrink the span mid-frame.
    write_reg(REG_SCREEN_WIDTH, 11'd8);
    write_reg(REG_SCREEN_HEIGHT, 11'd4);
    write_reg(REG_CLIP_TOP, '0);
    write_reg(REG_CLIP_BOTTOM, '1);
    write_reg(REG_CLIP_LEFT, 11'd3);
    write_reg(REG_CLIP_RIGHT, '1);
    push_byte(8'h11, 1'b1);
    push_byte(8'h22, 1'b0);
    push_byte(8'h33, 1'b0);
    push_byte(8'h44, 1'b0);
    wait_idle();
    write_reg(REG_CLIP_RIGHT, 11'd4);
    push_byte(8'h55, 1'b0);
    push_byte(8'h66, 1'b0);
    wait_idle();

    for (int ph = 0; ph < 9; ph++) begin
      set_idle(ph % 4);
      for (int sub = 0; sub < 2; sub++) begin
        wait_idle();
        if (ph == 1 && sub == 0)
          setup(1024, 1024, ORIENT_ROT180, 1'b1, 0, 1024, 0, 1024);
        else if (ph == 3 && sub == 0)
          setup(2047, 2047, ORIENT_NONE, 1'b0, 1023, 2047, 1021, 2047);
        else if (ph == 4 && sub == 0)
          setup(6, 4, ORIENT_LEFT, 1'b1, 0, 4, 0, 6);
        else if (ph == 5 && sub == 1)
          setup(2, 1, 2'($urandom_range(3)), 1'($urandom_range(1)), 0, 1, 0, 2);
        else
          random_setup();
        if (ph == 4 && sub == 0) begin
          // Stall the output long enough for the block to back up its input.
          hold_req = 1'b1;
          @(negedge clk);
          hold_req = 1'b0;
        end
        queue_frames(25);
      end
    end

    wait_idle();
    repeat (20) @(negedge clk);
    $display("ran %0d source bytes, %0d pixel words checked, %0d frame ends, %0d reg writes",
             bytes_taken, words_checked, frame_ends, reg_writes);
    $display("covered all orientations, both tints, clipped, empty and odd-width regions, stalls");
    if (errors == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
